### rtl/dirty_page_set_table_defines.svh
// ----------------------------------------------------------------------------
// Dirty page set table assertion macros
// Shared concurrent assertion forms, clocked on clk_i, reset by rst_ni.
// ----------------------------------------------------------------------------
`ifndef DIRTY_PAGE_SET_TABLE_DEFINES_SVH
`define DIRTY_PAGE_SET_TABLE_DEFINES_SVH

// generic property, disabled in reset
`define DPST_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// signal holds across the next edge while cond is true
`define DPST_ASSERT_STABLE(lbl, cond, sig, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) cond |=> $stable(sig)) \
    else $error(msg);

`endif

### rtl/dpst_pkg.sv
// ----------------------------------------------------------------------------
// Dirty page set table package
// Request/response payload types, action codes and sequencer states.
// ----------------------------------------------------------------------------
package dpst_pkg;

  localparam int unsigned PAGE_W  = 52;
  localparam int unsigned STAMP_W = 48;

  typedef enum logic [1:0] {
    ACT_INSERT = 2'd0,
    ACT_LOOKUP = 2'd1,
    ACT_RANGE  = 2'd2,
    ACT_CLEAR  = 2'd3
  } action_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_FINISH
  } state_e;

  typedef struct packed {
    logic [1:0]         action;
    logic [PAGE_W-1:0]  page;
    logic [PAGE_W-1:0]  range_end;
    logic [STAMP_W-1:0] stamp;
  } req_t;

  typedef struct packed {
    logic               status;
    logic               found;
    logic [PAGE_W-1:0]  match_page;
    logic [STAMP_W-1:0] match_stamp;
    logic               last;
  } rsp_t;

  typedef struct packed {
    logic [PAGE_W-1:0]  page;
    logic [STAMP_W-1:0] stamp;
  } entry_t;

endpackage

### rtl/dirty_page_set_table.sv
// ----------------------------------------------------------------------------
// Dirty page set table
// Insertion-ordered table of unique pages with timestamps: insert, lookup,
// inclusive range scan and clear.
// ----------------------------------------------------------------------------
// One request at a time. Entries live in a single-port-read RAM and are walked
// in insertion order, one entry per cycle through the RAM read port unless a
// held range match waits on a stalled output; insert and lookup stop at the
// first hit, and clear goes straight to its final response without a scan.
// A range scan delivers one response per match, the final one with last set,
// or one empty response if nothing matches. in_stall_o stays high from
// acceptance until the final response is loaded into the output register.
// Unwritten entries are never read: only entries below the fill count are
// scanned.
module dirty_page_set_table #(
  parameter int unsigned TABLE_DEPTH = 64
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_stall_o,
  input  dpst_pkg::req_t in_req_i,
  output logic           out_valid_o,
  input  logic           out_stall_i,
  output dpst_pkg::rsp_t out_rsp_o
);

  localparam int unsigned AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int unsigned CW = $clog2(TABLE_DEPTH + 1);

  dpst_pkg::state_e  state_q, state_d;
  dpst_pkg::req_t    req_q;
  dpst_pkg::action_e act;
  logic [CW-1:0]     count_q, idx_q;
  logic              rd_vld_q, pend_vld_q, out_valid_q;
  dpst_pkg::entry_t  pend_q, rdata;
  dpst_pkg::rsp_t    out_q, fin_rsp;

  logic in_acc, out_free, full, more;
  logic key_hit, in_range, hit_now, rng_hit, emit_mid, cmp_ok, rd_en;
  logic fin_emit, wr_en;

  assign act      = dpst_pkg::action_e'(req_q.action);
  assign in_acc   = in_valid_i && (state_q == dpst_pkg::ST_IDLE);
  assign out_free = !out_valid_q || !out_stall_i;
  assign full     = (count_q == CW'(TABLE_DEPTH));
  assign more     = (idx_q < count_q);

  assign key_hit  = (rdata.page == req_q.page);
  assign in_range = (rdata.page >= req_q.page) && (rdata.page <= req_q.range_end);
  assign hit_now  = (state_q == dpst_pkg::ST_SCAN) && rd_vld_q &&
                    (act != dpst_pkg::ACT_RANGE) && key_hit;
  assign rng_hit  = (state_q == dpst_pkg::ST_SCAN) && rd_vld_q &&
                    (act == dpst_pkg::ACT_RANGE) && in_range;
  // a second range match pushes the held one out
  assign emit_mid = rng_hit && pend_vld_q;
  assign cmp_ok   = rd_vld_q && (!emit_mid || out_free);
  assign rd_en    = (state_q == dpst_pkg::ST_SCAN) && more && !hit_now &&
                    (!rd_vld_q || cmp_ok);
  assign fin_emit = (state_q == dpst_pkg::ST_FINISH) && out_free;
  assign wr_en    = fin_emit && (act == dpst_pkg::ACT_INSERT) && !pend_vld_q && !full;

  dpst_entry_ram #(
    .DEPTH (TABLE_DEPTH),
    .AW    (AW)
  ) u_entry_ram (
    .clk_i   (clk_i),
    .we_i    (wr_en),
    .waddr_i (count_q[AW-1:0]),
    .wdata_i ({req_q.page, req_q.stamp}),
    .re_i    (rd_en),
    .raddr_i (idx_q[AW-1:0]),
    .rdata_o (rdata)
  );

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      dpst_pkg::ST_IDLE: begin
        if (in_valid_i) begin
          if (dpst_pkg::action_e'(in_req_i.action) == dpst_pkg::ACT_CLEAR) begin
            state_d = dpst_pkg::ST_FINISH;
          end else begin
            state_d = dpst_pkg::ST_SCAN;
          end
        end
      end
      dpst_pkg::ST_SCAN: begin
        if (hit_now || (!more && (!rd_vld_q || cmp_ok))) begin
          state_d = dpst_pkg::ST_FINISH;
        end
      end
      dpst_pkg::ST_FINISH: begin
        if (out_free) begin
          state_d = dpst_pkg::ST_IDLE;
        end
      end
      default: state_d = dpst_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    in_stall_o          = (state_q != dpst_pkg::ST_IDLE);
    fin_rsp.status      = (act == dpst_pkg::ACT_INSERT) && !pend_vld_q && full;
    fin_rsp.found       = pend_vld_q;
    fin_rsp.match_page  = pend_vld_q ? pend_q.page  : '0;
    fin_rsp.match_stamp = pend_vld_q ? pend_q.stamp : '0;
    fin_rsp.last        = 1'b1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= dpst_pkg::ST_IDLE;
      count_q     <= '0;
      idx_q       <= '0;
      rd_vld_q    <= 1'b0;
      pend_vld_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;

      if (in_acc) begin
        idx_q <= '0;
      end else if (rd_en) begin
        idx_q <= idx_q + 1'b1;
      end

      if (rd_en) begin
        rd_vld_q <= 1'b1;
      end else if (cmp_ok) begin
        rd_vld_q <= 1'b0;
      end

      if (in_acc) begin
        pend_vld_q <= 1'b0;
      end else if (cmp_ok && (hit_now || rng_hit)) begin
        pend_vld_q <= 1'b1;
      end

      if ((emit_mid && cmp_ok) || fin_emit) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end

      if (fin_emit) begin
        if (act == dpst_pkg::ACT_CLEAR) begin
          count_q <= '0;
        end else if (wr_en) begin
          count_q <= count_q + 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      req_q <= in_req_i;
    end
    if (cmp_ok && (hit_now || rng_hit)) begin
      pend_q <= rdata;
    end
    if (emit_mid && cmp_ok) begin
      out_q.status      <= 1'b0;
      out_q.found       <= 1'b1;
      out_q.match_page  <= pend_q.page;
      out_q.match_stamp <= pend_q.stamp;
      out_q.last        <= 1'b0;
    end else if (fin_emit) begin
      out_q <= fin_rsp;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_rsp_o   = out_q;

endmodule

### rtl/dpst_entry_ram.sv
// ----------------------------------------------------------------------------
// Dirty page set table entry RAM
// One write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module dpst_entry_ram #(
  parameter int unsigned DEPTH = 64,
  parameter int unsigned AW    = 6
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  dpst_pkg::entry_t wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output dpst_pkg::entry_t rdata_o
);

  dpst_pkg::entry_t mem_q [DEPTH];
  dpst_pkg::entry_t rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

### rtl/dpst_checker.sv
// ----------------------------------------------------------------------------
// Dirty page set table port checker
// Port-level properties of the table, bound to the top level.
// ----------------------------------------------------------------------------
`include "dirty_page_set_table_defines.svh"

module dpst_checker (
  input logic           clk_i,
  input logic           rst_ni,
  input logic           in_valid_i,
  input logic           in_stall_o,
  input logic           out_valid_o,
  input logic           out_stall_i,
  input dpst_pkg::rsp_t out_rsp_o
);

  `DPST_ASSERT(a_out_hold, out_valid_o && out_stall_i |=> out_valid_o, "response dropped while stalled")
  `DPST_ASSERT_STABLE(a_out_stable, out_valid_o && out_stall_i, out_rsp_o, "stalled response changed")
  `DPST_ASSERT(a_busy_after_req, in_valid_i && !in_stall_o |=> in_stall_o, "second request taken while busy")
  `DPST_ASSERT(a_miss_zero, out_valid_o && !out_rsp_o.found |-> out_rsp_o.match_page == '0 && out_rsp_o.match_stamp == '0, "miss carries nonzero payload")
  `DPST_ASSERT(a_full_final, out_valid_o && out_rsp_o.status |-> out_rsp_o.last && !out_rsp_o.found, "full status on non-final or hit response")

endmodule

bind dirty_page_set_table dpst_checker u_dpst_checker (.*);
